>>> rtl/assert_macros.svh
// Assertion helpers for the display byte-stream checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge, reset included.
`define CHK_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

// Checked only while reset is low.
`define CHK_RUN(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

`endif

>>> rtl/lcdg_pkg.sv
package lcdg_pkg;

  // request kinds
  localparam logic [1:0] KIND_GOTO  = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_PIXEL = 2'd2;

  // configuration register indexes
  localparam logic REG_COL_OFFSET   = 1'b0;
  localparam logic REG_REVERSE_CODE = 1'b1;

  localparam logic [7:0] RST_COL_OFFSET   = 8'd18;
  localparam logic [7:0] RST_REVERSE_CODE = 8'd1;

  localparam logic [7:0] CMD_PAGE     = 8'hB0;
  localparam logic [3:0] CMD_COL_HIGH = 4'h1;
  localparam logic [7:0] FIRST_CHAR   = 8'd32;  // space
  localparam logic [7:0] LAST_CHAR    = 8'd126; // tilde
  localparam int         GLYPHS       = 95;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] row;
    logic [7:0] col;
    logic [7:0] char_code;
    logic [7:0] attribute;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0] col_offset;
    logic [7:0] reverse_code;
  } cfg_t;

  // one-entry request slot handed to the sequencer
  typedef struct packed {
    logic valid;
    req_t req;
  } pend_t;

  // 5x7 font, five columns per glyph, leftmost column in the top byte
  localparam logic [39:0] GLYPH_COLS [0:GLYPHS-1] = '{
    40'h00_00_00_00_00, 40'h00_00_5f_00_00, 40'h00_07_00_07_00, 40'h14_7f_14_7f_14,
    40'h24_2a_7f_2a_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
    40'h00_1c_22_41_00, 40'h00_41_22_1c_00, 40'h14_08_3e_08_14, 40'h08_08_3e_08_08,
    40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
    40'h3e_51_49_45_3e, 40'h00_42_7f_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4b_31,
    40'h18_14_12_7f_10, 40'h27_45_45_45_39, 40'h3c_4a_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1e, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
    40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
    40'h32_49_79_41_3e, 40'h7e_11_11_11_7e, 40'h7f_49_49_49_36, 40'h3e_41_41_41_22,
    40'h7f_41_41_22_1c, 40'h7f_49_49_49_41, 40'h7f_09_09_09_01, 40'h3e_41_49_49_7a,
    40'h7f_08_08_08_7f, 40'h00_41_7f_41_00, 40'h20_40_41_3f_01, 40'h7f_08_14_22_41,
    40'h7f_40_40_40_40, 40'h7f_02_0c_02_7f, 40'h7f_04_08_10_7f, 40'h3e_41_41_41_3e,
    40'h7f_09_09_09_06, 40'h3e_41_51_21_5e, 40'h7f_09_19_29_46, 40'h46_49_49_49_31,
    40'h01_01_7f_01_01, 40'h3f_40_40_40_3f, 40'h1f_20_40_20_1f, 40'h3f_40_38_40_3f,
    40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7f_41_41_00,
    40'h02_04_08_10_20, 40'h00_41_41_7f_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
    40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7f_48_44_44_38, 40'h38_44_44_44_20,
    40'h38_44_44_48_7f, 40'h38_54_54_54_18, 40'h08_7e_09_01_02, 40'h0c_52_52_52_3e,
    40'h7f_08_04_04_78, 40'h00_44_7d_40_00, 40'h20_40_44_3d_00, 40'h7f_10_28_44_00,
    40'h00_41_7f_40_00, 40'h7c_04_18_04_78, 40'h7c_08_04_04_78, 40'h38_44_44_44_38,
    40'h7c_14_14_14_08, 40'h08_14_14_18_7c, 40'h7c_08_04_04_08, 40'h48_54_54_54_20,
    40'h04_3f_44_40_20, 40'h3c_40_40_20_7c, 40'h1c_20_40_20_1c, 40'h3c_40_30_40_3c,
    40'h44_28_10_28_44, 40'h0c_50_50_50_3c, 40'h44_64_54_4c_44, 40'h00_08_36_41_00,
    40'h00_00_7f_00_00, 40'h00_41_36_08_00, 40'h10_08_08_10_08
  };

endpackage

>>> rtl/lcdg_font_rom.sv
module lcdg_font_rom (
  input  logic        clk,
  input  logic        en,
  input  logic [6:0]  addr,
  output logic [39:0] cols
);

  // registered read; addr is only enabled for printable codes
  always_ff @(posedge clk) begin
    if (en) begin
      cols <= lcdg_pkg::GLYPH_COLS[addr];
    end
  end

endmodule

>>> rtl/lcdg_seq.sv
module lcdg_seq (
  input  logic            clk,
  input  logic            rst,
  input  lcdg_pkg::cfg_t  cfg,
  input  lcdg_pkg::pend_t pend,
  output logic            take,
  output logic            strobe,
  output lcdg_pkg::res_t  result
);

  lcdg_pkg::req_t cur;
  logic           act;
  logic           act_next;
  logic [2:0]     step;
  logic [2:0]     step_next;
  logic [2:0]     last_step;
  logic           cur_last;
  logic           pend_emits;
  logic           rom_en;
  logic [6:0]     code_idx;
  logic [39:0]    glyph;
  logic [7:0]     glyph_col;
  logic [7:0]     addr;
  logic [7:0]     byte_val;
  logic           byte_data;

  // glyph read is launched as the request enters, data lines up with step 0
  assign code_idx = 7'(pend.req.char_code - lcdg_pkg::FIRST_CHAR);
  assign rom_en   = take && pend_emits && (pend.req.kind == lcdg_pkg::KIND_CHAR);

  lcdg_font_rom u_rom (
    .clk  (clk),
    .en   (rom_en),
    .addr (code_idx),
    .cols (glyph)
  );

  always_comb begin
    case (pend.req.kind)
      lcdg_pkg::KIND_GOTO:  pend_emits = 1'b1;
      lcdg_pkg::KIND_PIXEL: pend_emits = 1'b1;
      lcdg_pkg::KIND_CHAR:  pend_emits =
          pend.req.char_code inside {[lcdg_pkg::FIRST_CHAR:lcdg_pkg::LAST_CHAR]};
      default:              pend_emits = 1'b0;
    endcase
  end

  always_comb begin
    case (cur.kind)
      lcdg_pkg::KIND_CHAR:  last_step = 3'd5;
      lcdg_pkg::KIND_PIXEL: last_step = 3'd3;
      default:              last_step = 3'd2;
    endcase
  end

  assign cur_last = (step == last_step);
  assign take     = pend.valid && (!act || cur_last);

  always_comb begin
    act_next  = act;
    step_next = step;
    if (take) begin
      act_next  = pend_emits;
      step_next = 3'd0;
    end else if (act) begin
      if (cur_last) begin
        act_next = 1'b0;
      end else begin
        step_next = step + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act  <= 1'b0;
      step <= 3'd0;
    end else begin
      act  <= act_next;
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= pend.req;
    end
  end

  // column address = col_offset + 6*col, mod 256
  assign addr = cfg.col_offset + {cur.col[5:0], 2'b00} + {cur.col[6:0], 1'b0};

  always_comb begin
    case (step)
      3'd0:    glyph_col = glyph[39:32];
      3'd1:    glyph_col = glyph[31:24];
      3'd2:    glyph_col = glyph[23:16];
      3'd3:    glyph_col = glyph[15:8];
      3'd4:    glyph_col = glyph[7:0];
      default: glyph_col = 8'h00; // blank spacer column
    endcase
  end

  always_comb begin
    byte_val  = 8'h00;
    byte_data = 1'b0;
    case (cur.kind)
      lcdg_pkg::KIND_GOTO: begin
        case (step)
          3'd0:    byte_val = lcdg_pkg::CMD_PAGE + {2'b00, cur.row};
          3'd1:    byte_val = {lcdg_pkg::CMD_COL_HIGH, addr[7:4]};
          default: byte_val = {4'h0, addr[3:0]};
        endcase
      end
      lcdg_pkg::KIND_CHAR: begin
        byte_data = 1'b1;
        if (cur.attribute == cfg.reverse_code) begin
          byte_val = ~glyph_col;
        end else begin
          byte_val = glyph_col | cur.attribute;
        end
      end
      lcdg_pkg::KIND_PIXEL: begin
        case (step)
          3'd0:    byte_val = lcdg_pkg::CMD_PAGE + {5'd0, cur.row[5:3]};
          3'd1:    byte_val = {lcdg_pkg::CMD_COL_HIGH, cur.col[7:4]};
          3'd2:    byte_val = {4'h0, cur.col[3:0]};
          default: begin
            byte_val  = 8'h01 << cur.row[2:0];
            byte_data = 1'b1;
          end
        endcase
      end
      default: begin
        byte_val  = 8'h00;
        byte_data = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= act;
    end
  end

  always_ff @(posedge clk) begin
    result <= '{out_byte: byte_val, is_data: byte_data, last: cur_last};
  end

endmodule

>>> rtl/lcd_text_pixel_command_generator_core.sv
// Byte-stream generator for a page-addressed monochrome LCD controller. Each
// request (go-to-cell, character, pixel) turns into a burst of bytes on result,
// one byte per clock with strobe high, each tagged as command or data, and the
// final byte of a request marked by last. The receiver cannot stall: every
// strobe cycle carries a byte that must be taken. Bursts are 3 bytes for a
// go-to-cell, 6 for a printable character (codes 32..126) and 4 for a pixel;
// unprintable characters and kind 3 produce nothing. An accepted request is
// registered in the input slot, then moves into the sequencer when it is free,
// and each of its bytes is registered onto result together with strobe. The
// one-byte-per-clock output sets the rate: a request holds the sequencer while
// its bytes go out, and a request waiting in the input slot moves in on the
// final byte of the one ahead, so bursts follow one another with no gap. busy
// is high while the input slot is full and not draining this cycle, and during
// reset. Glyph columns come from a 95-entry font ROM read once per character
// with a registered read. col_offset and reverse_code are written through
// wr_en/wr_index/wr_data; the user must write them only while no request is
// in flight, which the block itself does not enforce. There is no clearing
// pass after reset.
module lcd_text_pixel_command_generator_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  lcdg_pkg::req_t req,
  output logic           busy,
  output logic           strobe,
  output lcdg_pkg::res_t result,
  input  logic           wr_en,
  input  logic           wr_index,
  input  logic [7:0]     wr_data
);

  lcdg_pkg::cfg_t  cfg;
  lcdg_pkg::pend_t pend;
  logic            take;
  logic            accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.col_offset   <= lcdg_pkg::RST_COL_OFFSET;
      cfg.reverse_code <= lcdg_pkg::RST_REVERSE_CODE;
    end else if (wr_en) begin
      case (wr_index)
        lcdg_pkg::REG_COL_OFFSET:   cfg.col_offset   <= wr_data;
        lcdg_pkg::REG_REVERSE_CODE: cfg.reverse_code <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // Input slot: takes a request while the previous one is still being
  // emitted; frees up in the same cycle the sequencer pulls it.
  assign busy   = rst || (pend.valid && !take);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend.valid <= 1'b0;
    end else if (accept) begin
      pend.valid <= 1'b1;
    end else if (take) begin
      pend.valid <= 1'b0;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      pend.req <= req;
    end
  end

  lcdg_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pend   (pend),
    .take   (take),
    .strobe (strobe),
    .result (result)
  );

endmodule

>>> rtl/lcdg_checker.sv
`include "assert_macros.svh"

module lcdg_checker (
  input logic           clk,
  input logic           rst,
  input logic           busy,
  input logic           strobe,
  input lcdg_pkg::res_t result
);

  // reset leaves the block empty, and idle once reset drops
  `CHK_ALWAYS(a_reset_idle, clk, rst |=> (!strobe && (rst || !busy)), "not idle after reset")

  // a burst never breaks before its last byte
  `CHK_RUN(a_burst_contig, clk, rst, (strobe && !result.last) |=> strobe, "burst gap")

  // data bytes of a glyph run back to back until last
  `CHK_RUN(a_data_run, clk, rst, (strobe && result.is_data && !result.last) |=>
           (strobe && result.is_data), "glyph data broken")

  // a command that ends a request is the low column nibble
  `CHK_RUN(a_low_nibble, clk, rst, (strobe && result.last && !result.is_data) |->
           (result.out_byte[7:4] == 4'd0), "bad final command")

endmodule

bind lcd_text_pixel_command_generator_core lcdg_checker u_chk (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Predicts the byte stream for each accepted request and checks the bytes
// that come out against it, oldest first.
class byte_stream_predictor;
  logic [7:0]     col_offset;
  logic [7:0]     reverse_code;
  logic [39:0]    font_cols [0:94];
  lcdg_pkg::res_t pending_bytes [$];
  int             errors;

  function new();
    col_offset   = lcdg_pkg::RST_COL_OFFSET;
    reverse_code = lcdg_pkg::RST_REVERSE_CODE;
    errors       = 0;
    // 5x7 font, leftmost column in the top byte, codes 32..126
    font_cols = '{
      40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
      40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
      40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
      40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
      40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
      40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
      40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
      40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
      40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
      40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
      40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
      40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
      40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
      40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
      40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
      40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
      40'h00007f0000, 40'h0041360800, 40'h1008081008
    };
  endfunction

  function void set_reg(logic idx, logic [7:0] val);
    if (idx == lcdg_pkg::REG_COL_OFFSET) col_offset = val;
    else reverse_code = val;
  endfunction

  function int pending();
    return pending_bytes.size();
  endfunction

  function void push_byte(logic [7:0] val, logic is_data, logic last);
    lcdg_pkg::res_t b;
    b.out_byte = val;
    b.is_data  = is_data;
    b.last     = last;
    pending_bytes.push_back(b);
  endfunction

  function void note_request(lcdg_pkg::req_t r);
    logic [7:0]  addr;
    logic [7:0]  glyph_col;
    logic [39:0] glyph;
    bit          inverted;
    case (r.kind)
      lcdg_pkg::KIND_GOTO: begin
        // cell address wraps at 8 bits
        addr = col_offset + r.col * 8'd6;
        push_byte(lcdg_pkg::CMD_PAGE + {2'b00, r.row}, 1'b0, 1'b0);
        push_byte({lcdg_pkg::CMD_COL_HIGH, addr[7:4]}, 1'b0, 1'b0);
        push_byte({4'h0, addr[3:0]}, 1'b0, 1'b1);
      end
      lcdg_pkg::KIND_CHAR: begin
        if (r.char_code >= lcdg_pkg::FIRST_CHAR && r.char_code <= lcdg_pkg::LAST_CHAR) begin
          glyph    = font_cols[r.char_code - lcdg_pkg::FIRST_CHAR];
          inverted = (r.attribute == reverse_code);
          for (int k = 0; k < 5; k++) begin
            glyph_col = glyph[39 - 8 * k -: 8];
            push_byte(inverted ? ~glyph_col : (glyph_col | r.attribute), 1'b1, 1'b0);
          end
          // blank spacer column
          push_byte(inverted ? 8'hFF : r.attribute, 1'b1, 1'b1);
        end
      end
      lcdg_pkg::KIND_PIXEL: begin
        push_byte(lcdg_pkg::CMD_PAGE + {5'b00000, r.row[5:3]}, 1'b0, 1'b0);
        push_byte({lcdg_pkg::CMD_COL_HIGH, r.col[7:4]}, 1'b0, 1'b0);
        push_byte({4'h0, r.col[3:0]}, 1'b0, 1'b0);
        push_byte(8'h01 << r.row[2:0], 1'b1, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function void check_byte(lcdg_pkg::res_t got);
    lcdg_pkg::res_t want;
    if (pending_bytes.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected byte %h data=%b last=%b",
                 $realtime, got.out_byte, got.is_data, got.last);
      return;
    end
    want = pending_bytes.pop_front();
    if (got.out_byte !== want.out_byte || got.is_data !== want.is_data ||
        got.last !== want.last) begin
      errors++;
      if (errors <= 10)
        $display("%0t: byte mismatch: expected %h data=%b last=%b, got %h data=%b last=%b",
                 $realtime, want.out_byte, want.is_data, want.last,
                 got.out_byte, got.is_data, got.last);
    end
  endfunction
endclass

module tb_top;

  // kind code the block must ignore
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic           clk      = 1'b0;
  logic           rst      = 1'b1;
  logic           start    = 1'b0;
  lcdg_pkg::req_t req      = '0;
  logic           wr_en    = 1'b0;
  logic           wr_index = 1'b0;
  logic [7:0]     wr_data  = 8'h00;
  logic           busy;
  logic           strobe;
  lcdg_pkg::res_t result;

  byte_stream_predictor sb = new();
  lcdg_pkg::req_t       directed [$];

  lcd_text_pixel_command_generator_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .busy     (busy),
    .strobe   (strobe),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #5 clk = ~clk;

  // All inputs change on the rising edge, so the falling edge sees the values
  // that the next rising edge will act on. Requests are noted before bytes are
  // checked; a byte can never come out in the cycle its request is accepted.
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_request(req);
      if (strobe === 1'b1) sb.check_byte(result);
    end
  end

  // Hard stop in case the block hangs or never frees its input slot.
  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic lcdg_pkg::req_t make_req(logic [1:0] kind, logic [5:0] row,
                                              logic [7:0] col, logic [7:0] code,
                                              logic [7:0] attr);
    lcdg_pkg::req_t r;
    r.kind      = kind;
    r.row       = row;
    r.col       = col;
    r.char_code = code;
    r.attribute = attr;
    return r;
  endfunction

  // Requests that put at least one byte on the output.
  function automatic bit yields_bytes(lcdg_pkg::req_t r);
    if (r.kind == lcdg_pkg::KIND_CHAR)
      return r.char_code >= lcdg_pkg::FIRST_CHAR && r.char_code <= lcdg_pkg::LAST_CHAR;
    return r.kind != KIND_UNUSED;
  endfunction

  // Mostly well-formed requests with random content; the rest is noise that
  // the block should drop (kind 3, unprintable codes).
  function automatic lcdg_pkg::req_t random_request(logic [7:0] rev);
    lcdg_pkg::req_t r;
    int             pick;
    r    = lcdg_pkg::req_t'($urandom);
    pick = $urandom_range(99);
    if (pick < 28) begin
      r.kind = lcdg_pkg::KIND_GOTO;
    end else if (pick < 62) begin
      r.kind      = lcdg_pkg::KIND_CHAR;
      r.char_code = 8'($urandom_range(126, 32));
      case ($urandom_range(3))
        0: r.attribute = rev;
        1: r.attribute = 8'h00;
        default: ;
      endcase
    end else if (pick < 90) begin
      r.kind = lcdg_pkg::KIND_PIXEL;
    end else if (pick < 95) begin
      r.kind = KIND_UNUSED;
    end else begin
      r.kind      = lcdg_pkg::KIND_CHAR;
      r.char_code = pick[0] ? 8'($urandom_range(31)) : 8'($urandom_range(255, 127));
    end
    // keep columns mostly on screen, but let the wrap cases through too
    if (r.kind != lcdg_pkg::KIND_CHAR && $urandom_range(3) != 0)
      r.col = 8'($urandom_range(131));
    return r;
  endfunction

  // Hold start high until the block takes the request. Returns on the edge
  // that accepted it, so the caller can present the next one right away.
  task automatic send_request(input lcdg_pkg::req_t r);
    bit taken;
    req   <= r;
    start <= 1'b1;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  // Random gap on the request side, with junk on the bus while start is low.
  task automatic maybe_idle(input bit allow);
    if (allow && $urandom_range(99) < 14) begin
      start <= 1'b0;
      req   <= lcdg_pkg::req_t'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Registers may only change with nothing in flight. Dropped requests give
  // no byte to wait on, so allow a few cycles past the last byte for them.
  task automatic quiesce();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // One write, then the enable goes low again before the task returns.
  task automatic write_reg(input logic idx, input logic [7:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Only requests that make bytes count toward n_items.
  task automatic run_random(input int n_items, input bit allow_idle);
    int             produced = 0;
    lcdg_pkg::req_t r;
    while (produced < n_items) begin
      maybe_idle(allow_idle);
      r = random_request(sb.reverse_code);
      send_request(r);
      if (yields_bytes(r)) produced++;
    end
  endtask

  initial begin
    int guard;

    // Directed set, run at the reset register values (offset 18, reverse 1).
    directed.push_back(make_req(lcdg_pkg::KIND_GOTO, 6'd0, 8'd0, 8'h00, 8'h00));
    // unused operands
    directed.push_back(make_req(lcdg_pkg::KIND_GOTO, 6'd63, 8'd131, 8'hFF, 8'hFF));
    // address wrap
    directed.push_back(make_req(lcdg_pkg::KIND_GOTO, 6'd5, 8'd255, 8'h41, 8'h00));
    // space
    directed.push_back(make_req(lcdg_pkg::KIND_CHAR, 6'd0, 8'd0, 8'd32, 8'h00));
    // tilde
    directed.push_back(make_req(lcdg_pkg::KIND_CHAR, 6'd63, 8'd255, 8'd126, 8'hFF));
    directed.push_back(make_req(lcdg_pkg::KIND_CHAR, 6'd0, 8'd0, "A",
                                lcdg_pkg::RST_REVERSE_CODE));
    directed.push_back(make_req(lcdg_pkg::KIND_CHAR, 6'd0, 8'd0, "g", 8'h80));
    // just below printable
    directed.push_back(make_req(lcdg_pkg::KIND_CHAR, 6'd0, 8'd0, 8'd31, 8'h00));
    // just above printable
    directed.push_back(make_req(lcdg_pkg::KIND_CHAR, 6'd0, 8'd0, 8'd127, 8'h00));
    directed.push_back(make_req(lcdg_pkg::KIND_CHAR, 6'd0, 8'd0, 8'd0, 8'h00));
    directed.push_back(make_req(lcdg_pkg::KIND_CHAR, 6'd0, 8'd0, 8'd255, 8'h00));
    directed.push_back(make_req(lcdg_pkg::KIND_PIXEL, 6'd0, 8'd0, 8'h00, 8'h00));
    directed.push_back(make_req(lcdg_pkg::KIND_PIXEL, 6'd63, 8'd131, 8'h00, 8'h00));
    directed.push_back(make_req(lcdg_pkg::KIND_PIXEL, 6'd7, 8'd255, 8'h00, 8'h00));
    // unused operands
    directed.push_back(make_req(lcdg_pkg::KIND_PIXEL, 6'd42, 8'h5A, 8'h7E, 8'hC3));
    directed.push_back(make_req(KIND_UNUSED, 6'd63, 8'd255, 8'd65, 8'hFF));
    directed.push_back(make_req(lcdg_pkg::KIND_CHAR, 6'd0, 8'd0, 8'd126,
                                lcdg_pkg::RST_REVERSE_CODE));
    directed.push_back(make_req(lcdg_pkg::KIND_CHAR, 6'd0, 8'd0, 8'd32,
                                lcdg_pkg::RST_REVERSE_CODE));
    directed.push_back(make_req(lcdg_pkg::KIND_GOTO, 6'd63, 8'd0, 8'h20,
                                lcdg_pkg::RST_REVERSE_CODE));
    directed.push_back(make_req(lcdg_pkg::KIND_CHAR, 6'd0, 8'd0, "Z", 8'h00));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      maybe_idle(1'b1);
      send_request(directed[i]);
    end

    // Low extremes: zero offset, reverse on attribute 0.
    quiesce();
    write_reg(lcdg_pkg::REG_COL_OFFSET, 8'h00);
    write_reg(lcdg_pkg::REG_REVERSE_CODE, 8'h00);
    run_random(20, 1'b1);

    // High extremes, back to back with no gaps on the request side.
    quiesce();
    write_reg(lcdg_pkg::REG_COL_OFFSET, 8'hFF);
    write_reg(lcdg_pkg::REG_REVERSE_CODE, 8'hFF);
    run_random(20, 1'b0);

    quiesce();
    write_reg(lcdg_pkg::REG_COL_OFFSET, 8'($urandom));
    write_reg(lcdg_pkg::REG_REVERSE_CODE, 8'($urandom));
    run_random(20, 1'b1);

    quiesce();
    write_reg(lcdg_pkg::REG_REVERSE_CODE, 8'($urandom));
    write_reg(lcdg_pkg::REG_COL_OFFSET, 8'($urandom));
    run_random(20, 1'b1);

    // Drain, bounded, then a few more cycles for any stray bytes.
    start <= 1'b0;
    for (guard = 0; guard < 500 && sb.pending() != 0; guard++) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.pending() != 0)
      $display("%0d expected bytes never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
